FILE: rtl/jeue_pkg.sv
package jeue_pkg;

    // Up to six bytes come out of one character (the \u00xx escape).
    localparam int MaxBytes  = 6;
    localparam int CntW      = $clog2(MaxBytes + 1);
    localparam int IdxW      = $clog2(MaxBytes);
    localparam int CpW       = 21;

    localparam int FifoDepth = 4;
    localparam int PtrW      = $clog2(FifoDepth);
    localparam int FillW     = $clog2(FifoDepth + 1);

    // Byte run for one character, first byte in slot 0.
    typedef struct packed {
        logic [MaxBytes-1:0][7:0] bytes;
        logic [CntW-1:0]          cnt;
    } t_desc;

endpackage

FILE: rtl/jeue_front.sv
module jeue_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [jeue_pkg::CpW-1:0]     i_code_point,
    output logic                         o_push,
    output jeue_pkg::t_desc              o_desc,
    input  logic                         i_fifo_ready
);

    localparam logic [7:0] ChQuote = 8'h22;
    localparam logic [7:0] ChBslash = 8'h5C;
    localparam logic [7:0] ChLf = 8'h0A;
    localparam logic [7:0] ChCr = 8'h0D;
    localparam logic [7:0] ChTab = 8'h09;
    localparam logic [7:0] ChN = 8'h6E;
    localparam logic [7:0] ChR = 8'h72;
    localparam logic [7:0] ChT = 8'h74;
    localparam logic [7:0] ChU = 8'h75;
    localparam logic [7:0] ChZero = 8'h30;

    localparam logic [jeue_pkg::CpW-1:0] CpCtlEnd  = 21'h00020;
    localparam logic [jeue_pkg::CpW-1:0] CpAscEnd  = 21'h00080;
    localparam logic [jeue_pkg::CpW-1:0] CpSurLo   = 21'h0D800;
    localparam logic [jeue_pkg::CpW-1:0] CpSurHi   = 21'h0DFFF;
    localparam logic [jeue_pkg::CpW-1:0] CpTwoEnd  = 21'h00800;
    localparam logic [jeue_pkg::CpW-1:0] CpThrEnd  = 21'h10000;

    function automatic logic [7:0] hex_lower(input logic [3:0] nib);
        logic [7:0] w;
        begin
            w = {4'h0, nib};
            hex_lower = (nib < 4'd10) ? (ChZero + w) : (8'h57 + w);
        end
    endfunction

    logic            r_valid;
    logic            n_valid;
    jeue_pkg::t_desc r_desc;
    jeue_pkg::t_desc n_desc;
    logic            accept;
    logic [jeue_pkg::CpW-1:0] c;

    assign c          = i_code_point;
    assign o_in_ready = !r_valid || i_fifo_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign o_push     = r_valid && i_fifo_ready;
    assign o_desc     = r_desc;

    always_comb begin
        n_desc.bytes = '0;
        n_desc.cnt   = '0;
        if (c[7:0] == ChQuote && c[20:8] == '0 || c[7:0] == ChBslash && c[20:8] == '0) begin
            n_desc.bytes[0] = ChBslash;
            n_desc.bytes[1] = c[7:0];
            n_desc.cnt      = jeue_pkg::CntW'(2);
        end else if (c == {13'h0, ChLf}) begin
            n_desc.bytes[0] = ChBslash;
            n_desc.bytes[1] = ChN;
            n_desc.cnt      = jeue_pkg::CntW'(2);
        end else if (c == {13'h0, ChCr}) begin
            n_desc.bytes[0] = ChBslash;
            n_desc.bytes[1] = ChR;
            n_desc.cnt      = jeue_pkg::CntW'(2);
        end else if (c == {13'h0, ChTab}) begin
            n_desc.bytes[0] = ChBslash;
            n_desc.bytes[1] = ChT;
            n_desc.cnt      = jeue_pkg::CntW'(2);
        end else if (c < CpCtlEnd) begin
            n_desc.bytes[0] = ChBslash;
            n_desc.bytes[1] = ChU;
            n_desc.bytes[2] = ChZero;
            n_desc.bytes[3] = ChZero;
            n_desc.bytes[4] = hex_lower(c[7:4]);
            n_desc.bytes[5] = hex_lower(c[3:0]);
            n_desc.cnt      = jeue_pkg::CntW'(6);
        end else if (c < CpAscEnd) begin
            n_desc.bytes[0] = c[7:0];
            n_desc.cnt      = jeue_pkg::CntW'(1);
        end else if (c >= CpSurLo && c <= CpSurHi) begin
            n_desc.cnt      = '0;
        end else if (c < CpTwoEnd) begin
            n_desc.bytes[0] = {3'b110, c[10:6]};
            n_desc.bytes[1] = {2'b10, c[5:0]};
            n_desc.cnt      = jeue_pkg::CntW'(2);
        end else if (c < CpThrEnd) begin
            n_desc.bytes[0] = {4'b1110, c[15:12]};
            n_desc.bytes[1] = {2'b10, c[11:6]};
            n_desc.bytes[2] = {2'b10, c[5:0]};
            n_desc.cnt      = jeue_pkg::CntW'(3);
        end else begin
            n_desc.bytes[0] = {5'b11110, c[20:18]};
            n_desc.bytes[1] = {2'b10, c[17:12]};
            n_desc.bytes[2] = {2'b10, c[11:6]};
            n_desc.bytes[3] = {2'b10, c[5:0]};
            n_desc.cnt      = jeue_pkg::CntW'(4);
        end
    end

    // Drop surrogates right here: they never take a queue slot.
    always_comb begin
        if (accept) begin
            n_valid = (n_desc.cnt != '0);
        end else begin
            n_valid = r_valid && !o_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_desc <= n_desc;
        end
    end

endmodule

FILE: rtl/jeue_fifo.sv
module jeue_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  jeue_pkg::t_desc i_data,
    output logic            o_ready,
    output logic            o_valid,
    output jeue_pkg::t_desc o_data,
    input  logic            i_pop
);

    jeue_pkg::t_desc                r_mem [jeue_pkg::FifoDepth];
    logic [jeue_pkg::PtrW-1:0]      r_wptr;
    logic [jeue_pkg::PtrW-1:0]      r_rptr;
    logic [jeue_pkg::FillW-1:0]     r_fill;
    logic                           do_push;
    logic                           do_pop;

    assign o_ready = (r_fill != jeue_pkg::FillW'(jeue_pkg::FifoDepth));
    assign o_valid = (r_fill != '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_fill <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (do_pop && !do_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

FILE: rtl/jeue_back.sv
module jeue_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_head_valid,
    input  jeue_pkg::t_desc i_head,
    output logic            o_pop,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_last_of_char
);

    logic [jeue_pkg::IdxW-1:0] r_idx;
    logic                      r_out_valid;
    logic [7:0]                r_out_byte;
    logic                      r_out_last;
    logic                      load;
    logic                      is_last;

    assign load    = i_head_valid && (!r_out_valid || i_out_ready);
    assign is_last = (r_idx == jeue_pkg::IdxW'(i_head.cnt - 1'b1));
    assign o_pop   = load && is_last;

    assign o_out_valid    = r_out_valid;
    assign o_out_byte     = r_out_byte;
    assign o_last_of_char = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_idx       <= is_last ? '0 : r_idx + 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_byte <= i_head.bytes[r_idx];
            r_out_last <= is_last;
        end
    end

endmodule

FILE: rtl/json_escape_utf8_encoder_top.sv
// JSON string escaper and UTF-8 encoder.
// Input channel: one 21-bit character code per beat (i_in_valid / o_in_ready).
// Output channel: one byte per beat (o_out_valid / i_out_ready), with
// o_last_of_char high on the final byte of each character's run.
// Quote and backslash get a backslash prefix; LF, CR and TAB become \n, \r
// and \t; other control codes become \u00xx; higher codes become 2 to 4 byte
// UTF-8. Surrogate codes produce no bytes at all.
// Path: the first byte of a character passes the classifier register, a
// queue entry and the output register on its way out.
// Throughput: one input beat per cycle while o_in_ready is high; the byte
// serializer emits one byte per cycle while bytes are queued and i_out_ready
// is high. A four-entry queue between the classifier and the serializer
// absorbs short bursts of multi-byte characters.
// Stall: when i_out_ready is low the output register holds its byte, the
// queue fills, and o_in_ready drops once the classifier stage is also full.
// Reset (i_rst_n low, synchronous) empties every stage; no bytes are lost
// or emitted after it except those for beats accepted afterwards.
module json_escape_utf8_encoder_top (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [jeue_pkg::CpW-1:0] i_code_point,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [7:0]               o_out_byte,
    output logic                     o_last_of_char
);

    logic            push;
    jeue_pkg::t_desc push_desc;
    logic            fifo_ready;
    logic            head_valid;
    jeue_pkg::t_desc head;
    logic            pop;

    // Classify each character into its byte run; drop surrogates.
    jeue_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_code_point (i_code_point),
        .o_push       (push),
        .o_desc       (push_desc),
        .i_fifo_ready (fifo_ready)
    );

    // Decouple the classifier from the byte serializer.
    jeue_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_desc),
        .o_ready (fifo_ready),
        .o_valid (head_valid),
        .o_data  (head),
        .i_pop   (pop)
    );

    // Walk the head run one byte per beat; pop on its last byte.
    jeue_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head_valid   (head_valid),
        .i_head         (head),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_byte     (o_out_byte),
        .o_last_of_char (o_last_of_char)
    );

endmodule

FILE: dv/tb_json_escape_utf8_encoder_top.sv
module tb_json_escape_utf8_encoder_top;

    localparam int CpW = jeue_pkg::CpW;

    // Character codes that get a backslash escape.
    localparam logic [7:0] ChQuote  = 8'h22;
    localparam logic [7:0] ChBslash = 8'h5C;
    localparam logic [7:0] ChLf     = 8'h0A;
    localparam logic [7:0] ChCr     = 8'h0D;
    localparam logic [7:0] ChTab    = 8'h09;

    localparam logic [CpW-1:0] SurrLo   = 21'h00D800;
    localparam logic [CpW-1:0] SurrHi   = 21'h00DFFF;
    localparam logic [CpW-1:0] UniMax   = 21'h10FFFF;

    localparam int NumDirected = 24;
    localparam int RandItems   = 390;
    localparam int HoldCycles  = 150;
    localparam int CycleLimit  = 400000;
    localparam int MaxPrints   = 30;

    // One character offered to the block: either with its byte run typed in
    // (text order, first byte in the top eight bits) or left to the predictor.
    typedef struct packed {
        logic [CpW-1:0] cp;
        logic           typed;
        logic [2:0]     n;
        logic [47:0]    txt;
    } t_char_row;

    // One byte the block owes us.
    typedef struct packed {
        logic [7:0]     data;
        logic           last;
        logic [CpW-1:0] cp;
    } t_esc_byte;

    typedef enum logic [1:0] {RxFull, RxCoin, RxSparse, RxPeriodic} t_rx_mode;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_in_valid;
    logic           o_in_ready;
    logic [CpW-1:0] i_code_point;
    logic           o_out_valid;
    logic           i_out_ready;
    logic [7:0]     o_out_byte;
    logic           o_last_of_char;

    json_escape_utf8_encoder_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_code_point   (i_code_point),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_byte     (o_out_byte),
        .o_last_of_char (o_last_of_char)
    );

    t_char_row dir_rows [NumDirected];
    t_char_row offered_chars [$];   // driven but not yet taken by the block
    t_esc_byte owed_bytes [$];      // predicted bytes not yet seen on the output

    int  errors;
    int  cycles;
    int  n_accepted;
    int  n_bytes;
    int  n_silent;
    int  n_beyond;
    int  n_in_stalls;
    bit  hold_pending;

    // Free-running clock, period 8.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog: give up well past the slowest legal run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("timeout after %0d cycles, %0d bytes still owed", cycles,
                     owed_bytes.size());
            $display("json_escape_utf8_encoder_top regression: fail");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        if (errors < MaxPrints)
            $display("mismatch @%0d: %s", cycles, msg);
        errors++;
    endtask

    function automatic logic [7:0] hex_lc(input logic [3:0] v);
        return (v < 4'd10) ? 8'h30 + v : 8'h57 + v;
    endfunction

    // Byte run for one character, in text order from the top of txt.
    function automatic int escape_char(input logic [CpW-1:0] c, output logic [47:0] txt);
        txt = '0;
        if (c == CpW'(ChQuote) || c == CpW'(ChBslash)) begin
            txt = {ChBslash, c[7:0], 32'h0};
            return 2;
        end else if (c == CpW'(ChLf)) begin
            txt = {ChBslash, 8'h6E, 32'h0};
            return 2;
        end else if (c == CpW'(ChCr)) begin
            txt = {ChBslash, 8'h72, 32'h0};
            return 2;
        end else if (c == CpW'(ChTab)) begin
            txt = {ChBslash, 8'h74, 32'h0};
            return 2;
        end else if (c < 21'h20) begin
            // remaining control codes: \u00xx, lower-case hex
            txt = {ChBslash, 8'h75, 8'h30, 8'h30, hex_lc(c[7:4]), hex_lc(c[3:0])};
            return 6;
        end else if (c < 21'h80) begin
            txt = {c[7:0], 40'h0};
            return 1;
        end else if (c >= SurrLo && c <= SurrHi) begin
            return 0;
        end else if (c < 21'h800) begin
            txt = {3'b110, c[10:6], 2'b10, c[5:0], 32'h0};
            return 2;
        end else if (c < 21'h10000) begin
            txt = {4'b1110, c[15:12], 2'b10, c[11:6], 2'b10, c[5:0], 24'h0};
            return 3;
        end
        // four-byte form; codes past the Unicode range keep the same pattern
        txt = {5'b11110, c[20:18], 2'b10, c[17:12], 2'b10, c[11:6], 2'b10, c[5:0], 16'h0};
        return 4;
    endfunction

    // Weighted pick across every encoding class, plus raw 21-bit noise.
    function automatic logic [CpW-1:0] pick_code();
        logic [CpW-1:0] specials [5];
        specials = '{21'(ChQuote), 21'(ChBslash), 21'(ChLf), 21'(ChCr), 21'(ChTab)};
        case ($urandom_range(0, 9))
            0: return specials[$urandom_range(0, 4)];
            1: return 21'($urandom_range(0, 'h1F));
            2: return 21'($urandom_range('h20, 'h7F));
            3: return 21'($urandom_range('h80, 'h7FF));
            4: return 21'($urandom_range('h800, 'hFFFF));
            5: return 21'($urandom_range(SurrLo, SurrHi));
            6: return 21'($urandom_range('h10000, UniMax));
            7: return 21'($urandom_range(UniMax + 1, 21'h1FFFFF));
            default: return 21'($urandom);
        endcase
    endfunction

    // Sample both channels at the rising edge. On an input beat, turn the
    // character into owed bytes; on an output beat, check against the oldest.
    always @(posedge i_clk) begin
        t_char_row row;
        t_esc_byte want;
        logic [47:0] txt;
        int n;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_ready)
                n_in_stalls++;
            if (i_in_valid && o_in_ready) begin
                if (offered_chars.size() == 0) begin
                    report_mismatch("input beat taken with nothing offered");
                end else begin
                    row = offered_chars.pop_front();
                    if (row.cp !== i_code_point)
                        report_mismatch($sformatf("offered %h but bus shows %h",
                                                  row.cp, i_code_point));
                    if (row.typed) begin
                        n   = int'(row.n);
                        txt = row.txt;
                    end else begin
                        n = escape_char(row.cp, txt);
                    end
                    n_accepted++;
                    if (n == 0)
                        n_silent++;
                    if (row.cp > UniMax)
                        n_beyond++;
                    for (int k = 0; k < n; k++) begin
                        want.data = txt[47 - 8 * k -: 8];
                        want.last = (k == n - 1);
                        want.cp   = row.cp;
                        owed_bytes.push_back(want);
                    end
                end
            end
            if (o_out_valid && i_out_ready) begin
                n_bytes++;
                if (owed_bytes.size() == 0) begin
                    report_mismatch($sformatf("unexpected byte %h last %b",
                                              o_out_byte, o_last_of_char));
                end else begin
                    want = owed_bytes.pop_front();
                    if (o_out_byte !== want.data)
                        report_mismatch($sformatf("cp %h: byte %h, want %h",
                                                  want.cp, o_out_byte, want.data));
                    if (o_last_of_char !== want.last)
                        report_mismatch($sformatf("cp %h byte %h: last %b, want %b",
                                                  want.cp, want.data, o_last_of_char,
                                                  want.last));
                end
            end
        end
    end

    // Receiver: switch between randomly drawn stall patterns; on request hold off
    // for a long stretch so the queue fills and the input backs up.
    initial begin
        t_rx_mode mode;
        int       tick;
        i_out_ready = 1'b0;
        tick = 0;
        mode = RxFull;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_pending) begin
                i_out_ready <= 1'b0;
                repeat (HoldCycles) @(negedge i_clk);
                hold_pending = 1'b0;
            end else begin
                tick++;
                if (tick % 50 == 0)
                    mode = t_rx_mode'($urandom_range(0, 3));
                case (mode)
                    RxFull:     i_out_ready <= 1'b1;
                    RxCoin:     i_out_ready <= 1'($urandom_range(0, 1));
                    RxSparse:   i_out_ready <= ($urandom_range(0, 4) == 0);
                    RxPeriodic: i_out_ready <= (tick[1:0] != 2'b00);
                endcase
            end
        end
    end

    // Offer one character; hold valid and payload until the block takes it.
    // Returns at the falling edge after the beat, with valid still high.
    task automatic send_char(input t_char_row row);
        offered_chars.push_back(row);
        i_in_valid   <= 1'b1;
        i_code_point <= row.cp;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    // Drop valid for an idle gap of length n; n == 0 leaves valid as it is.
    task automatic idle_cycles(input int n);
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    // Pause the sender until every owed byte has come out.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (owed_bytes.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        t_char_row row;
        int        sent;
        int        burst;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_code_point = '0;
        errors       = 0;
        cycles       = 0;
        n_accepted   = 0;
        n_bytes      = 0;
        n_silent     = 0;
        n_beyond     = 0;
        n_in_stalls  = 0;
        hold_pending = 1'b0;

        // Directed rows: extremes of each encoding class, every escape,
        // both ends of the surrogate range, and codes past U+10FFFF.
        dir_rows = '{
            '{21'h000000, 1'b1, 3'd6, 48'h5C75_3030_3030},
            '{21'h00001F, 1'b1, 3'd6, 48'h5C75_3030_3166},
            '{21'h000022, 1'b1, 3'd2, 48'h5C22_0000_0000},
            '{21'h00005C, 1'b1, 3'd2, 48'h5C5C_0000_0000},
            '{21'h00000A, 1'b1, 3'd2, 48'h5C6E_0000_0000},
            '{21'h00000D, 1'b1, 3'd2, 48'h5C72_0000_0000},
            '{21'h000009, 1'b1, 3'd2, 48'h5C74_0000_0000},
            '{21'h00007F, 1'b1, 3'd1, 48'h7F00_0000_0000},
            '{21'h000080, 1'b1, 3'd2, 48'hC280_0000_0000},
            '{21'h0007FF, 1'b1, 3'd2, 48'hDFBF_0000_0000},
            '{21'h000800, 1'b1, 3'd3, 48'hE0A0_8000_0000},
            '{21'h00FFFF, 1'b1, 3'd3, 48'hEFBF_BF00_0000},
            '{21'h010000, 1'b1, 3'd4, 48'hF090_8080_0000},
            '{21'h10FFFF, 1'b1, 3'd4, 48'hF48F_BFBF_0000},
            '{21'h00D800, 1'b1, 3'd0, 48'h0},
            '{21'h00DFFF, 1'b1, 3'd0, 48'h0},
            '{21'h110000, 1'b1, 3'd4, 48'hF490_8080_0000},
            '{21'h1FFFFF, 1'b1, 3'd4, 48'hF7BF_BFBF_0000},
            '{21'h000041, 1'b0, 3'd0, 48'h0},
            '{21'h00001B, 1'b0, 3'd0, 48'h0},
            '{21'h00D7FF, 1'b0, 3'd0, 48'h0},
            '{21'h00E000, 1'b0, 3'd0, 48'h0},
            '{21'h00DC00, 1'b0, 3'd0, 48'h0},
            '{21'h0003A9, 1'b0, 3'd0, 48'h0}
        };

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[k]) begin
            send_char(dir_rows[k]);
            idle_cycles($urandom_range(0, 2));
        end
        wait_drained();

        // Random bursts. Around item 150 ask the receiver for a long hold-off
        // and keep offering back to back; around item 300 drain fully; items
        // 200 to 260 run with no sender gaps.
        sent = 0;
        while (sent < RandItems) begin
            burst = $urandom_range(1, 16);
            repeat (burst) begin
                row.cp    = pick_code();
                row.typed = 1'b0;
                row.n     = '0;
                row.txt   = '0;
                send_char(row);
                sent++;
                if (sent == 150)
                    hold_pending = 1'b1;
                if (sent == 300)
                    wait_drained();
            end
            if (hold_pending || (sent >= 200 && sent < 260))
                idle_cycles(0);
            else if ($urandom_range(0, 3) == 0)
                idle_cycles(0);
            else
                idle_cycles($urandom_range(1, 6));
        end

        // Wait out every owed byte, then wait on for strays.
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (owed_bytes.size() != 0) @(negedge i_clk);
        repeat (16) @(negedge i_clk);

        if (owed_bytes.size() != 0)
            report_mismatch($sformatf("%0d bytes never arrived", owed_bytes.size()));

        $display("covered %0d characters (%0d directed), %0d bytes checked", n_accepted,
                 NumDirected, n_bytes);
        $display("%0d surrogates with no output, %0d codes past U+10FFFF, %0d input stalls",
                 n_silent, n_beyond, n_in_stalls);
        if (errors == 0) begin
            $display("json_escape_utf8_encoder_top regression: pass");
        end else begin
            $display("%0d mismatches", errors);
            $display("json_escape_utf8_encoder_top regression: fail");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/jeue_pkg.sv
rtl/jeue_front.sv
rtl/jeue_fifo.sv
rtl/jeue_back.sv
rtl/json_escape_utf8_encoder_top.sv
dv/tb_json_escape_utf8_encoder_top.sv
